// ===== src/npt_pkg.sv =====
// Shared constants, codes and the cell control struct for the node presence table.
// Used by npt_cell, npt_chain and node_presence_table_with_aging; no dependencies.
`default_nettype none

package npt_pkg;

    localparam int unsigned TABLE_ENTRIES = 64;
    localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned CFG_IDX_W = 4;

    localparam logic [CNT_W-1:0] USED_MAX = CNT_W'(TABLE_ENTRIES);

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_NODE_TIMEOUT    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_STATUS_INTERVAL = CFG_IDX_W'(1);

    localparam logic [DATA_W-1:0] NODE_TIMEOUT_RST    = DATA_W'(30000);
    localparam logic [DATA_W-1:0] STATUS_INTERVAL_RST = DATA_W'(10000);

    // input mode codes
    localparam logic MODE_SEEN = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // result kind codes
    localparam logic [1:0] KIND_SEEN  = 2'd0;
    localparam logic [1:0] KIND_LIST  = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    // Broadcast control for every cell of the chain.
    typedef struct packed {
        logic              shift;      // take the right neighbor's entry
        logic              ins_en;     // while shifting, the cell at pos takes the head entry
        logic [IDX_W-1:0]  pos;
        logic              seen_en;    // seen beat: refresh a match
        logic              append_en;  // seen beat: the cell at used takes the new id
        logic [DATA_W-1:0] seen_id;
        logic [DATA_W-1:0] now;
        logic [CNT_W-1:0]  used;
    } ctrl_t;

endpackage

`default_nettype wire

// ===== src/npt_cell.sv =====
// One table slot: node id and last-seen time, with refresh, append and shift.
// Depends on npt_pkg.
`default_nettype none

module npt_cell (
    input  wire logic                           clk,
    input  wire npt_pkg::ctrl_t                 ctrl,
    input  wire logic [npt_pkg::IDX_W-1:0]      slot,
    input  wire logic [npt_pkg::DATA_W-1:0]     right_id,
    input  wire logic [npt_pkg::DATA_W-1:0]     right_time,
    input  wire logic [npt_pkg::DATA_W-1:0]     head_id,
    input  wire logic [npt_pkg::DATA_W-1:0]     head_time,
    output logic      [npt_pkg::DATA_W-1:0]     id,
    output logic      [npt_pkg::DATA_W-1:0]     seen_time,
    output logic                                hit
);

    logic [npt_pkg::DATA_W-1:0] id_reg;
    logic [npt_pkg::DATA_W-1:0] id_next;
    logic [npt_pkg::DATA_W-1:0] time_reg;
    logic [npt_pkg::DATA_W-1:0] time_next;
    logic                       occupied;
    logic                       append_here;

    assign occupied    = npt_pkg::CNT_W'(slot) < ctrl.used;
    assign hit         = ctrl.seen_en && occupied && (id_reg == ctrl.seen_id);
    assign append_here = ctrl.seen_en && ctrl.append_en && (npt_pkg::CNT_W'(slot) == ctrl.used);

    always_comb
    begin
        id_next   = id_reg;
        time_next = time_reg;
        if (ctrl.shift)
        begin
            if (ctrl.ins_en && (slot == ctrl.pos))
            begin
                id_next   = head_id;
                time_next = head_time;
            end
            else
            begin
                id_next   = right_id;
                time_next = right_time;
            end
        end
        else if (hit)
        begin
            time_next = ctrl.now;
        end
        else if (append_here)
        begin
            id_next   = ctrl.seen_id;
            time_next = ctrl.now;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        time_reg <= time_next;
    end

    assign id        = id_reg;
    assign seen_time = time_reg;

endmodule

`default_nettype wire

// ===== src/npt_chain.sv =====
// Row of npt_cell slots linked left to right, with the head slot exposed
// and the match lines reduced to one hit flag. Depends on npt_pkg, npt_cell.
`default_nettype none

module npt_chain (
    input  wire logic                       clk,
    input  wire npt_pkg::ctrl_t             ctrl,
    output logic [npt_pkg::DATA_W-1:0]      head_id,
    output logic [npt_pkg::DATA_W-1:0]      head_time,
    output logic                            any_hit
);

    logic [npt_pkg::DATA_W-1:0]        ids   [npt_pkg::TABLE_ENTRIES];
    logic [npt_pkg::DATA_W-1:0]        times [npt_pkg::TABLE_ENTRIES];
    logic [npt_pkg::DATA_W-1:0]        r_ids [npt_pkg::TABLE_ENTRIES];
    logic [npt_pkg::DATA_W-1:0]        r_times [npt_pkg::TABLE_ENTRIES];
    logic [npt_pkg::TABLE_ENTRIES-1:0] hits;

    genvar g;
    generate
        for (g = 0; g < npt_pkg::TABLE_ENTRIES; g++)
        begin : g_cell
            if (g == npt_pkg::TABLE_ENTRIES - 1)
            begin : g_tail
                assign r_ids[g]   = '0;
                assign r_times[g] = '0;
            end
            else
            begin : g_link
                assign r_ids[g]   = ids[g+1];
                assign r_times[g] = times[g+1];
            end

            npt_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .slot       (npt_pkg::IDX_W'(g)),
                .right_id   (r_ids[g]),
                .right_time (r_times[g]),
                .head_id    (ids[0]),
                .head_time  (times[0]),
                .id         (ids[g]),
                .seen_time  (times[g]),
                .hit        (hits[g])
            );
        end
    endgenerate

    assign head_id   = ids[0];
    assign head_time = times[0];
    assign any_hit   = |hits;

endmodule

`default_nettype wire

// ===== src/node_presence_table_with_aging.sv =====
// Top level of the node presence table: sequencer, config registers, output beat register.
// Depends on npt_pkg and npt_chain (which holds the npt_cell row).
`default_nettype none

// Node presence table with timeout aging. Up to TABLE_ENTRIES node ids are kept in a
// row of cells in order of first sight. A seen beat (mode 0) is matched against all
// cells at once, refreshes or appends, and yields one result, so seen beats flow at
// one per cycle while the output beat is taken and at most one result waits. A tick
// beat (mode 1) that finds status_interval elapsed since the last acting tick walks
// the table through the head cell: it tests the age of each stored entry in turn at
// the single age comparator there and compacts the survivors in order, then lists
// each survivor through the single output beat register (or gives one empty-list
// beat); no input is taken until the pass is done. A tick that comes too early gives
// no result. Configuration writes are always ready.
module node_presence_table_with_aging (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [npt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [npt_pkg::DATA_W-1:0]         cfg_data,

    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               mode,
    input  wire logic [npt_pkg::DATA_W-1:0]         node_id,
    input  wire logic [npt_pkg::DATA_W-1:0]         now,

    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [1:0]                              kind,
    output logic [npt_pkg::DATA_W-1:0]              listed_id,
    output logic                                    is_new,
    output logic                                    dropped,
    output logic [6:0]                              entry_count,
    output logic                                    last
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_COMPACT = 2'd1;
    localparam logic [1:0] ST_LIST    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic [npt_pkg::CNT_W-1:0]    used_reg, used_next;
    logic [npt_pkg::CNT_W-1:0]    pend_reg, pend_next;
    logic [npt_pkg::CNT_W-1:0]    keep_reg, keep_next;
    logic [npt_pkg::CNT_W-1:0]    list_reg, list_next;
    logic [npt_pkg::DATA_W-1:0]   last_status_reg, last_status_next;
    logic [npt_pkg::DATA_W-1:0]   tick_now_reg, tick_now_next;
    logic [npt_pkg::DATA_W-1:0]   timeout_reg;
    logic [npt_pkg::DATA_W-1:0]   interval_reg;

    logic                         out_valid_reg, out_valid_next;
    logic [1:0]                   kind_reg, kind_next;
    logic [npt_pkg::DATA_W-1:0]   id_reg, id_next;
    logic                         is_new_reg, is_new_next;
    logic                         dropped_reg, dropped_next;
    logic [npt_pkg::CNT_W-1:0]    count_reg, count_next;
    logic                         last_reg, last_next;

    npt_pkg::ctrl_t               ctrl;
    logic [npt_pkg::DATA_W-1:0]   head_id;
    logic [npt_pkg::DATA_W-1:0]   head_time;
    logic                         any_hit;

    logic                         in_fire;
    logic                         can_load;
    logic                         load;
    logic                         head_keep;
    logic                         tick_due;
    logic                         list_done;
    logic [npt_pkg::CNT_W-1:0]    compact_pos;

    npt_chain u_chain (
        .clk       (clk),
        .ctrl      (ctrl),
        .head_id   (head_id),
        .head_time (head_time),
        .any_hit   (any_hit)
    );

    assign cfg_ready = 1'b1;
    assign can_load  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE) || !can_load;
    assign in_fire   = in_valid && !in_stall;

    assign head_keep   = (tick_now_reg - head_time) < timeout_reg;
    assign tick_due    = !((now - last_status_reg) < interval_reg);
    assign list_done   = (list_reg + npt_pkg::CNT_W'(1)) == used_reg;
    assign compact_pos = pend_reg - npt_pkg::CNT_W'(1) + keep_reg;

    always_comb
    begin
        state_next       = state_reg;
        used_next        = used_reg;
        pend_next        = pend_reg;
        keep_next        = keep_reg;
        list_next        = list_reg;
        last_status_next = last_status_reg;
        tick_now_next    = tick_now_reg;

        ctrl           = '0;
        ctrl.seen_id   = node_id;
        ctrl.now       = now;
        ctrl.used      = used_reg;

        // hold the output beat unless a new one is loaded
        load         = 1'b0;
        kind_next    = kind_reg;
        id_next      = id_reg;
        is_new_next  = is_new_reg;
        dropped_next = dropped_reg;
        count_next   = count_reg;
        last_next    = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (mode == npt_pkg::MODE_SEEN))
                begin
                    ctrl.seen_en   = 1'b1;
                    ctrl.append_en = !any_hit && (used_reg < npt_pkg::USED_MAX);
                    used_next      = used_reg + npt_pkg::CNT_W'(ctrl.append_en);
                    load           = 1'b1;
                    kind_next      = npt_pkg::KIND_SEEN;
                    id_next        = node_id;
                    is_new_next    = ctrl.append_en;
                    dropped_next   = !any_hit && (used_reg == npt_pkg::USED_MAX);
                    count_next     = used_next;
                    last_next      = 1'b1;
                end
                else if (in_fire && tick_due)
                begin
                    last_status_next = now;
                    tick_now_next    = now;
                    pend_next        = used_reg;
                    keep_next        = '0;
                    state_next       = (used_reg == '0) ? ST_EMPTY : ST_COMPACT;
                end
            end

            ST_COMPACT:
            begin
                // drop the head or reinsert it behind the survivors kept so far
                ctrl.shift  = 1'b1;
                ctrl.ins_en = head_keep;
                ctrl.pos    = compact_pos[npt_pkg::IDX_W-1:0];
                keep_next   = keep_reg + npt_pkg::CNT_W'(head_keep);
                pend_next   = pend_reg - npt_pkg::CNT_W'(1);
                if (pend_reg == npt_pkg::CNT_W'(1))
                begin
                    used_next  = keep_next;
                    list_next  = '0;
                    state_next = (keep_next == '0) ? ST_EMPTY : ST_LIST;
                end
            end

            ST_LIST:
            begin
                if (can_load)
                begin
                    // rotate the survivors so each reaches the head once
                    ctrl.shift   = 1'b1;
                    ctrl.ins_en  = 1'b1;
                    ctrl.pos     = npt_pkg::IDX_W'(used_reg - npt_pkg::CNT_W'(1));
                    load         = 1'b1;
                    kind_next    = npt_pkg::KIND_LIST;
                    id_next      = head_id;
                    is_new_next  = 1'b0;
                    dropped_next = 1'b0;
                    count_next   = used_reg;
                    last_next    = list_done;
                    list_next    = list_reg + npt_pkg::CNT_W'(1);
                    if (list_done)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_EMPTY:
            begin
                if (can_load)
                begin
                    load         = 1'b1;
                    kind_next    = npt_pkg::KIND_EMPTY;
                    id_next      = '0;
                    is_new_next  = 1'b0;
                    dropped_next = 1'b0;
                    count_next   = '0;
                    last_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            used_reg        <= '0;
            pend_reg        <= '0;
            keep_reg        <= '0;
            list_reg        <= '0;
            last_status_reg <= '0;
            out_valid_reg   <= 1'b0;
            timeout_reg     <= npt_pkg::NODE_TIMEOUT_RST;
            interval_reg    <= npt_pkg::STATUS_INTERVAL_RST;
        end
        else
        begin
            state_reg       <= state_next;
            used_reg        <= used_next;
            pend_reg        <= pend_next;
            keep_reg        <= keep_next;
            list_reg        <= list_next;
            last_status_reg <= last_status_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_valid && cfg_ready && (cfg_index == npt_pkg::REG_NODE_TIMEOUT))
            begin
                timeout_reg <= cfg_data;
            end
            if (cfg_valid && cfg_ready && (cfg_index == npt_pkg::REG_STATUS_INTERVAL))
            begin
                interval_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tick_now_reg <= tick_now_next;
        kind_reg     <= kind_next;
        id_reg       <= id_next;
        is_new_reg   <= is_new_next;
        dropped_reg  <= dropped_next;
        count_reg    <= count_next;
        last_reg     <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign listed_id   = id_reg;
    assign is_new      = is_new_reg;
    assign dropped     = dropped_reg;
    assign entry_count = 7'(count_reg);
    assign last        = last_reg;

`ifndef SYNTH
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= npt_pkg::USED_MAX)
        else $error("entry count above table size");

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input taken while a tick pass is running");

    a_compact_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMPACT) |-> (pend_reg != '0) && (keep_reg < pend_reg + keep_reg + 1'b1)
            && ((pend_reg + keep_reg) <= used_reg))
        else $error("compaction counters out of step");

    a_list_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LIST) && can_load && list_done |=> (state_reg == ST_IDLE)
            && out_valid_reg && last_reg && (kind_reg == npt_pkg::KIND_LIST))
        else $error("final listed beat not flagged last");

    a_seen_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (kind_reg == npt_pkg::KIND_SEEN) |-> !(is_new_reg && dropped_reg))
        else $error("seen result both appended and dropped");
`endif

endmodule

`default_nettype wire

// ===== test/node_presence_table_with_aging_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for node_presence_table_with_aging: directed and random seen/tick
// beats under random sender gaps and receiver stalls, checked against a behavioral table.
// Depends on npt_pkg and the node_presence_table_with_aging RTL.

module node_presence_table_with_aging_tb;

    localparam int FRESH_ID_PCT = 20;
    localparam int POOL_MAX     = 128;
    localparam int MAX_PRINTS   = 40;

    typedef struct packed {
        logic [1:0]                 kind;
        logic [npt_pkg::DATA_W-1:0] id;
        logic                       is_new;
        logic                       dropped;
        logic [6:0]                 count;
        logic                       last;
    } node_beat_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [npt_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [npt_pkg::DATA_W-1:0]    cfg_data;
    logic                          in_valid;
    logic                          in_stall;
    logic                          mode;
    logic [npt_pkg::DATA_W-1:0]    node_id;
    logic [npt_pkg::DATA_W-1:0]    now;
    logic                          out_valid;
    logic                          out_stall;
    logic [1:0]                    kind;
    logic [npt_pkg::DATA_W-1:0]    listed_id;
    logic                          is_new;
    logic                          dropped;
    logic [6:0]                    entry_count;
    logic                          last;

    // behavioral copy of the table and its registers
    logic [npt_pkg::DATA_W-1:0] known_ids [npt_pkg::TABLE_ENTRIES];
    logic [npt_pkg::DATA_W-1:0] heard_at [npt_pkg::TABLE_ENTRIES];
    int                         known_count;
    logic [npt_pkg::DATA_W-1:0] last_status_at;
    logic [npt_pkg::DATA_W-1:0] timeout_reg;
    logic [npt_pkg::DATA_W-1:0] interval_reg;

    node_beat_t                 beats_due[$];
    int                         err_count;
    int                         burst_left;
    int                         gap_max;
    logic [npt_pkg::DATA_W-1:0] clock_ms;
    logic [npt_pkg::DATA_W-1:0] id_pool [POOL_MAX];

    node_presence_table_with_aging u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // receiver: free-flowing, light and heavy random stalls, then a fixed pattern
    initial
    begin
        int unsigned cyc;
        cyc = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            case ((cyc / 300) % 4)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 99) < 30);
                2:       out_stall <= ($urandom_range(0, 99) < 75);
                default: out_stall <= ((cyc % 7) < 3);
            endcase
        end
    end

    task automatic report_error(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("%0t: mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [npt_pkg::DATA_W-1:0] got,
                               input logic [npt_pkg::DATA_W-1:0] want);
        if (got !== want)
            report_error($sformatf("%s got %h want %h", name, got, want));
    endtask

    always @(posedge clk)
    begin : result_check
        node_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (beats_due.size() == 0)
                report_error($sformatf("unexpected beat kind %0d id %h", kind, listed_id));
            else
            begin
                want = beats_due.pop_front();
                check_field("kind", kind, want.kind);
                check_field("listed_id", listed_id, want.id);
                check_field("is_new", is_new, want.is_new);
                check_field("dropped", dropped, want.dropped);
                check_field("entry_count", entry_count, want.count);
                check_field("last", last, want.last);
            end
        end
    end

    // Apply one accepted beat to the table copy and queue the results it causes.
    function automatic void age_table_step(input logic m,
                                           input logic [npt_pkg::DATA_W-1:0] id,
                                           input logic [npt_pkg::DATA_W-1:0] t);
        node_beat_t                 r;
        int                         hit;
        int                         keep;
        logic [npt_pkg::DATA_W-1:0] span;
        r = '0;
        hit = -1;
        if (m == npt_pkg::MODE_SEEN)
        begin
            for (int i = 0; i < known_count; i++)
                if (hit < 0 && known_ids[i] == id)
                    hit = i;
            r.kind = npt_pkg::KIND_SEEN;
            r.id   = id;
            r.last = 1'b1;
            if (hit >= 0)
                heard_at[hit] = t;
            else if (known_count < npt_pkg::TABLE_ENTRIES)
            begin
                known_ids[known_count] = id;
                heard_at[known_count]  = t;
                known_count++;
                r.is_new = 1'b1;
            end
            else
                r.dropped = 1'b1;
            r.count = 7'(known_count);
            beats_due.push_back(r);
            return;
        end
        span = t - last_status_at;
        if (span < interval_reg)
            return;
        last_status_at = t;
        keep = 0;
        for (int i = 0; i < known_count; i++)
        begin
            span = t - heard_at[i];
            if (span < timeout_reg)
            begin
                known_ids[keep] = known_ids[i];
                heard_at[keep]  = heard_at[i];
                keep++;
            end
        end
        known_count = keep;
        if (keep == 0)
        begin
            r.kind = npt_pkg::KIND_EMPTY;
            r.last = 1'b1;
            beats_due.push_back(r);
        end
        for (int i = 0; i < keep; i++)
        begin
            r.kind  = npt_pkg::KIND_LIST;
            r.id    = known_ids[i];
            r.count = 7'(keep);
            r.last  = (i == keep - 1);
            beats_due.push_back(r);
        end
    endfunction

    // Send one beat in the current burst; open a new burst after a random gap.
    task automatic send_event(input logic m, input logic [npt_pkg::DATA_W-1:0] id,
                              input logic [npt_pkg::DATA_W-1:0] t);
        int gap;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(0, gap_max);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        mode     <= m;
        node_id  <= id;
        now      <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        age_table_step(m, id, t);
    endtask

    // Hold off until every queued result is out, then let a too-early tick finish.
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (beats_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [npt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [npt_pkg::DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            npt_pkg::REG_NODE_TIMEOUT:    timeout_reg = val;
            npt_pkg::REG_STATUS_INTERVAL: interval_reg = val;
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [npt_pkg::DATA_W-1:0] timeout_val,
                                input logic [npt_pkg::DATA_W-1:0] interval_val);
        write_reg(npt_pkg::REG_NODE_TIMEOUT, timeout_val);
        write_reg(npt_pkg::REG_STATUS_INTERVAL, interval_val);
        // an index past the register list must leave both registers alone
        write_reg(npt_pkg::CFG_IDX_W'($urandom_range(npt_pkg::REG_STATUS_INTERVAL + 1,
                                                     {npt_pkg::CFG_IDX_W{1'b1}})),
                  $urandom);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int n, input int pool_n, input int step_max,
                             input int tick_pct, input bit wild_now);
        logic [npt_pkg::DATA_W-1:0] id;
        logic                       m;
        for (int i = 0; i < pool_n; i++)
            id_pool[i] = $urandom;
        for (int k = 0; k < n; k++)
        begin
            m  = ($urandom_range(0, 99) < tick_pct) ? npt_pkg::MODE_TICK : npt_pkg::MODE_SEEN;
            id = ($urandom_range(0, 99) < FRESH_ID_PCT) ? $urandom
                                                         : id_pool[$urandom_range(0, pool_n - 1)];
            if (wild_now)
                clock_ms = $urandom;
            else
                clock_ms += $urandom_range(0, step_max);
            send_event(m, id, clock_ms);
        end
    endtask

    // reset registers: refresh, append, early and exact-boundary ticks, aging out
    task automatic test_seen_and_tick_basics();
        gap_max = 4;
        send_event(npt_pkg::MODE_SEEN, 32'h0000_0000, 32'd0);
        send_event(npt_pkg::MODE_SEEN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_event(npt_pkg::MODE_SEEN, 32'h0000_0000, 32'd5);
        send_event(npt_pkg::MODE_SEEN, 32'hAAAA_AAAA, 32'd10);
        send_event(npt_pkg::MODE_SEEN, 32'h5555_5555, 32'd20);
        send_event(npt_pkg::MODE_TICK, 32'hFFFF_FFFF, 32'd9999);
        send_event(npt_pkg::MODE_TICK, 32'h0000_0000, 32'd10000);
        send_event(npt_pkg::MODE_SEEN, 32'hAAAA_AAAA, 32'd39000);
        send_event(npt_pkg::MODE_TICK, 32'h1234_5678, 32'd40005);
        send_event(npt_pkg::MODE_TICK, 32'h0000_0000, 32'd40006);
        send_event(npt_pkg::MODE_TICK, 32'h0000_0000, 32'd80000);
        send_event(npt_pkg::MODE_SEEN, 32'h0000_1234, 32'd80000);
        send_event(npt_pkg::MODE_TICK, 32'h0000_0000, 32'd110000);
        send_event(npt_pkg::MODE_SEEN, 32'h0000_5678, 32'd110001);
        send_event(npt_pkg::MODE_TICK, 32'h0000_0000, 32'd140000);
    endtask

    // zero timeout and interval, then both at their maximum
    task automatic test_config_extremes();
        drain();
        program_regs(32'd0, 32'd0);
        send_event(npt_pkg::MODE_SEEN, 32'hDEAD_0001, 32'd150000);
        send_event(npt_pkg::MODE_SEEN, 32'hDEAD_0002, 32'd150000);
        send_event(npt_pkg::MODE_TICK, 32'h0000_0000, 32'd150000);
        send_event(npt_pkg::MODE_TICK, 32'h0000_0000, 32'd150000);
        send_event(npt_pkg::MODE_SEEN, 32'hDEAD_0003, 32'd150001);
        drain();
        program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_event(npt_pkg::MODE_SEEN, 32'hDEAD_0004, 32'd1000);
        send_event(npt_pkg::MODE_TICK, 32'h0000_0000, last_status_at + 32'd5);
        send_event(npt_pkg::MODE_TICK, 32'h0000_0000, last_status_at - 32'd1);
    endtask

    // fill the table past its size, then list all entries with one acting tick
    task automatic test_table_overflow();
        drain();
        program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        gap_max = 6;
        clock_ms = 32'd200000;
        run_phase(100, 120, 50, 5, 1'b0);
        send_event(npt_pkg::MODE_TICK, $urandom, last_status_at - 32'd1);
    endtask

    task automatic test_random_aging();
        drain();
        program_regs(32'd1, 32'd0);
        gap_max = 0;
        run_phase(37, 10, 2, 30, 1'b0);
        drain();
        program_regs(32'd300, 32'd100);
        gap_max = 6;
        run_phase(37, 12, 60, 25, 1'b0);
        drain();
        clock_ms = 32'hFFFF_F000;
        program_regs($urandom_range(1, 5000), $urandom_range(0, 2000));
        gap_max = 3;
        run_phase(37, 40, 400, 20, 1'b0);
        drain();
        program_regs($urandom, $urandom);
        gap_max = 8;
        run_phase(37, 24, 0, 25, 1'b1);
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        mode      <= npt_pkg::MODE_SEEN;
        node_id   <= '0;
        now       <= '0;
        known_count    = 0;
        last_status_at = '0;
        timeout_reg    = npt_pkg::NODE_TIMEOUT_RST;
        interval_reg   = npt_pkg::STATUS_INTERVAL_RST;
        err_count      = 0;
        burst_left     = 0;
        gap_max        = 0;
        clock_ms       = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_seen_and_tick_basics();
        test_config_extremes();
        test_table_overflow();
        test_random_aging();
        drain();

        if (err_count == 0 && beats_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
